[src/sharpen_conv3x3_zero_pad_top_defines.svh]
// Assertion macros used by the sharpen filter top level.
`ifndef SHARPEN_CONV3X3_ZERO_PAD_TOP_DEFINES_SVH
`define SHARPEN_CONV3X3_ZERO_PAD_TOP_DEFINES_SVH

// Check a property on the rising clock edge, quiet while reset is asserted.
`define SHC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication whose consequent is checked in the cycle after the antecedent.
`define SHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/shconv_pkg.sv]
`timescale 1ns / 1ps

package shconv_pkg;

  localparam int unsigned Rows    = 32;
  localparam int unsigned Cols    = 32;
  localparam int unsigned RowW    = $clog2(Rows);
  localparam int unsigned ColW    = $clog2(Cols);
  localparam int unsigned PixW    = 8;
  localparam int unsigned LineLen = 2 * Cols + 1;
  localparam int unsigned SumW    = PixW + 4;

  localparam int unsigned KernCenter = 5;
  localparam int unsigned PixMax     = 255;

  typedef struct packed {
    logic [PixW-1:0] n;
    logic [PixW-1:0] w;
    logic [PixW-1:0] c;
    logic [PixW-1:0] e;
    logic [PixW-1:0] s;
  } win_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_e;

endpackage

[src/shconv_line.sv]
`timescale 1ns / 1ps

module shconv_line (
  input  logic                         clk_i,
  input  logic                         shift_i,
  input  logic [shconv_pkg::PixW-1:0]  pix_i,
  output shconv_pkg::win_t             taps_o
);

  logic [shconv_pkg::PixW-1:0] line_q [shconv_pkg::LineLen];

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      line_q[0] <= pix_i;
      for (int i = 1; i < int'(shconv_pkg::LineLen); i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  assign taps_o.s = line_q[0];
  assign taps_o.e = line_q[shconv_pkg::Cols-1];
  assign taps_o.c = line_q[shconv_pkg::Cols];
  assign taps_o.w = line_q[shconv_pkg::Cols+1];
  assign taps_o.n = line_q[2*shconv_pkg::Cols];

endmodule

[src/shconv_kernel.sv]
`timescale 1ns / 1ps

module shconv_kernel (
  input  shconv_pkg::win_t             win_i,
  input  shconv_pkg::border_t          border_i,
  output logic [shconv_pkg::PixW-1:0]  pix_o
);

  logic [shconv_pkg::PixW-1:0]        n_v, s_v, w_v, e_v;
  logic [shconv_pkg::SumW-1:0]        pos_v, neg_v;
  logic signed [shconv_pkg::SumW:0]   diff_v;

  always_comb begin
    // zero the neighbors that fall outside the frame
    n_v = border_i.top    ? '0 : win_i.n;
    s_v = border_i.bottom ? '0 : win_i.s;
    w_v = border_i.left   ? '0 : win_i.w;
    e_v = border_i.right  ? '0 : win_i.e;

    pos_v = shconv_pkg::SumW'(win_i.c) * shconv_pkg::SumW'(shconv_pkg::KernCenter);
    neg_v = shconv_pkg::SumW'(n_v) + shconv_pkg::SumW'(s_v)
          + shconv_pkg::SumW'(w_v) + shconv_pkg::SumW'(e_v);
    diff_v = $signed({1'b0, pos_v}) - $signed({1'b0, neg_v});

    priority if (diff_v < 0) begin
      pix_o = '0;
    end else if (diff_v > $signed((shconv_pkg::SumW+1)'(shconv_pkg::PixMax))) begin
      pix_o = shconv_pkg::PixW'(shconv_pkg::PixMax);
    end else begin
      pix_o = diff_v[shconv_pkg::PixW-1:0];
    end
  end

endmodule

[src/sharpen_conv3x3_zero_pad_top.sv]
`timescale 1ns / 1ps
// Ordering: output pixel o is loaded into the result register when input o+COLS+1
//   is accepted; the final input of a frame starts a flush of COLS+1 more results.
// Throughput: one pixel per cycle in both directions while out_ready_i is held high;
//   input is held off during the flush.
// Reset: asynchronous, active low; clears counters, flush state and output valid.
`include "sharpen_conv3x3_zero_pad_top_defines.svh"

module sharpen_conv3x3_zero_pad_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [shconv_pkg::PixW-1:0]  pixel_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [shconv_pkg::PixW-1:0]  pixel_out_o,
  output logic                         frame_end_o
);

  shconv_pkg::state_e state_q, state_d;

  logic [shconv_pkg::RowW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [shconv_pkg::ColW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;

  logic out_valid_q, out_valid_d;
  logic [shconv_pkg::PixW-1:0] pixel_out_q;
  logic frame_end_q;

  logic advance, in_fire, flush_step, emit, shift_en, past_lead, last_in, last_out;
  logic [shconv_pkg::PixW-1:0] shift_pix, result_pix;
  shconv_pkg::win_t    taps;
  shconv_pkg::border_t border;

  assign advance   = !out_valid_q || out_ready_i;
  assign last_in   = (in_row_q == shconv_pkg::RowW'(shconv_pkg::Rows-1))
                  && (in_col_q == shconv_pkg::ColW'(shconv_pkg::Cols-1));
  assign last_out  = (out_row_q == shconv_pkg::RowW'(shconv_pkg::Rows-1))
                  && (out_col_q == shconv_pkg::ColW'(shconv_pkg::Cols-1));
  assign past_lead = (in_row_q >= shconv_pkg::RowW'(2))
                  || ((in_row_q == shconv_pkg::RowW'(1)) && (in_col_q != '0));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      shconv_pkg::ST_RUN: begin
        if (in_fire && last_in) begin
          state_d = shconv_pkg::ST_FLUSH;
        end
      end
      shconv_pkg::ST_FLUSH: begin
        if (flush_step && last_out) begin
          state_d = shconv_pkg::ST_RUN;
        end
      end
      default: state_d = shconv_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    flush_step = 1'b0;
    unique case (state_q)
      shconv_pkg::ST_RUN:   in_ready_o = advance;
      shconv_pkg::ST_FLUSH: flush_step = advance;
      default: begin
        in_ready_o = 1'b0;
        flush_step = 1'b0;
      end
    endcase
  end

  assign in_fire   = in_valid_i && in_ready_o;
  assign emit      = (in_fire && past_lead) || flush_step;
  assign shift_en  = in_fire || flush_step;
  assign shift_pix = in_fire ? pixel_in_i : '0;

  assign border.top    = (out_row_q == '0);
  assign border.bottom = (out_row_q == shconv_pkg::RowW'(shconv_pkg::Rows-1));
  assign border.left   = (out_col_q == '0);
  assign border.right  = (out_col_q == shconv_pkg::ColW'(shconv_pkg::Cols-1));

  shconv_line u_line (
    .clk_i   (clk_i),
    .shift_i (shift_en),
    .pix_i   (shift_pix),
    .taps_o  (taps)
  );

  shconv_kernel u_kernel (
    .win_i    (taps),
    .border_i (border),
    .pix_o    (result_pix)
  );

  always_comb begin
    in_row_d = in_row_q;
    in_col_d = in_col_q;
    if (in_fire) begin
      priority if (last_in) begin
        in_row_d = '0;
        in_col_d = '0;
      end else if (in_col_q == shconv_pkg::ColW'(shconv_pkg::Cols-1)) begin
        in_row_d = in_row_q + shconv_pkg::RowW'(1);
        in_col_d = '0;
      end else begin
        in_col_d = in_col_q + shconv_pkg::ColW'(1);
      end
    end
  end

  always_comb begin
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (emit) begin
      priority if (last_out) begin
        out_row_d = '0;
        out_col_d = '0;
      end else if (out_col_q == shconv_pkg::ColW'(shconv_pkg::Cols-1)) begin
        out_row_d = out_row_q + shconv_pkg::RowW'(1);
        out_col_d = '0;
      end else begin
        out_col_d = out_col_q + shconv_pkg::ColW'(1);
      end
    end
  end

  assign out_valid_d = advance ? emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shconv_pkg::ST_RUN;
      in_row_q    <= '0;
      in_col_q    <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_row_q    <= in_row_d;
      in_col_q    <= in_col_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pixel_out_q <= result_pix;
      frame_end_q <= last_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;
  assign frame_end_o = frame_end_q;

  `SHC_ASSERT(a_no_input_in_flush, clk_i, rst_ni, (state_q == shconv_pkg::ST_FLUSH) |-> !in_ready_o, "input accepted during flush")
  `SHC_ASSERT_NEXT(a_last_in_flush, clk_i, rst_ni, in_fire && last_in, state_q == shconv_pkg::ST_FLUSH, "last input did not start flush")
  `SHC_ASSERT_NEXT(a_frame_end_idle, clk_i, rst_ni, emit && last_out, (state_q == shconv_pkg::ST_RUN) && (in_row_q == '0) && (in_col_q == '0) && (out_row_q == '0) && (out_col_q == '0), "counters not cleared after frame end")

endmodule
